// ----- hdl/cubic_bezier_easing_eval_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cubic Bezier easing evaluator
// Shared forms of concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EASING_EVAL_TOP_MACROS_SVH
`define CUBIC_BEZIER_EASING_EVAL_TOP_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent, outside reset.
`define CBE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("port check failed");

// Consequence must hold in the cycle after the antecedent, outside reset.
`define CBE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("port check failed");

// Consequence must hold in the cycle after reset is applied.
`define CBE_ASSERT_RESET(label, clk, rstn, cons) \
    label: assert property (@(posedge clk) !(rstn) |=> (cons)) \
        else $error("reset check failed");

`endif

// ----- hdl/cbe_pkg.sv -----
// ----------------------------------------------------------------------------
// cbe_pkg
// Types, constants and the control point table of the easing evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbe_pkg;

    localparam int U_BITS    = 24;
    localparam int FRAC_BITS = 16;
    localparam int ROM_SIZE  = 8;
    localparam int NUM_CURVES = 8;

    localparam logic [2:0]  DEFAULT_CURVE = 3'd5;
    localparam logic [2:0]  LINEAR_CURVE  = 3'd0;
    localparam logic [17:0] Y_ONE = 18'd65536;
    localparam logic [17:0] Y_MAX = 18'd131071;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_ONE,
        MODE_LIN,
        MODE_CURVE
    } mode_t;

    // Control word that travels alongside each word in the pipeline.
    typedef struct packed {
        mode_t       mode;
        logic [2:0]  cid;
        logic [15:0] tq;
        logic [23:0] lo;
        logic [23:0] mid;
    } ctrl_t;

    typedef struct packed {
        logic [16:0] x1;
        logic [16:0] y1;
        logic [16:0] x2;
        logic [16:0] y2;
    } curve_t;

    // Control points quantised to Q16, rounded to nearest.
    function automatic curve_t curve_rom(input logic [2:0] cid);
        curve_t c;
        case (cid)
            3'd0:    c = '{17'd0,     17'd0,      17'd65536, 17'd65536};
            3'd1:    c = '{17'd15073, 17'd65536,  17'd20972, 17'd65536};
            3'd2:    c = '{17'd42598, 17'd3277,   17'd23593, 17'd65536};
            3'd3:    c = '{17'd32768, 17'd32768,  17'd49152, 17'd65536};
            3'd4:    c = '{17'd9830,  17'd0,      17'd6554,  17'd65536};
            3'd5:    c = '{17'd10486, 17'd65536,  17'd19661, 17'd65536};
            3'd6:    c = '{17'd22282, 17'd102236, 17'd41943, 17'd65536};
            3'd7:    c = '{17'd10486, 17'd81265,  17'd19661, 17'd65536};
            default: c = '{17'd0,     17'd0,      17'd65536, 17'd65536};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cbe_eval.sv -----
// ----------------------------------------------------------------------------
// cbe_eval
// Three-stage evaluation of one Bezier axis at the parameter mid of a word.
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_eval #(
    parameter bit AXIS_Y = 1'b0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  cbe_pkg::ctrl_t     in_ctrl,
    output logic               out_valid,
    output cbe_pkg::ctrl_t     out_ctrl,
    output logic [42:0]        out_pa,
    output logic [42:0]        out_pb,
    output logic [39:0]        out_pc
);
    import cbe_pkg::*;

    logic        a_valid_reg, b_valid_reg, c_valid_reg;
    ctrl_t       a_ctrl_reg, b_ctrl_reg, c_ctrl_reg;
    logic [24:0] a_mm_reg;
    logic [23:0] a_uu_reg;
    logic [25:0] a_m3_reg, a_u3_reg;
    logic [25:0] b_b1_reg, b_b2_reg;
    logic [23:0] b_b3_reg;
    logic [42:0] c_pa_reg, c_pb_reg;
    logic [39:0] c_pc_reg;

    logic [24:0] m;
    logic [49:0] mm_full;
    logic [47:0] uu_full;
    logic [50:0] b1_full;
    logic [49:0] b2_full;
    logic [47:0] b3_full;
    logic [16:0] p1, p2;
    curve_t      crv;

    always_comb begin
        m       = 25'h100_0000 - {1'b0, in_ctrl.mid};
        mm_full = 50'(m) * 50'(m);
        uu_full = 48'(in_ctrl.mid) * 48'(in_ctrl.mid);
        b1_full = 51'(a_mm_reg) * 51'(a_u3_reg);
        b2_full = 50'(a_m3_reg) * 50'(a_uu_reg);
        b3_full = 48'(a_uu_reg) * 48'(a_ctrl_reg.mid);
        crv     = curve_rom(b_ctrl_reg.cid);
        p1      = AXIS_Y ? crv.y1 : crv.x1;
        p2      = AXIS_Y ? crv.y2 : crv.x2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_ctrl_reg <= in_ctrl;
            a_mm_reg   <= mm_full[48:24];
            a_uu_reg   <= uu_full[47:24];
            a_m3_reg   <= {1'b0, m} + {m, 1'b0};
            a_u3_reg   <= {2'b00, in_ctrl.mid} + {1'b0, in_ctrl.mid, 1'b0};
            b_ctrl_reg <= a_ctrl_reg;
            b_b1_reg   <= b1_full[49:24];
            b_b2_reg   <= b2_full[49:24];
            b_b3_reg   <= b3_full[47:24];
            c_ctrl_reg <= b_ctrl_reg;
            c_pa_reg   <= 43'(b_b1_reg) * 43'(p1);
            c_pb_reg   <= 43'(b_b2_reg) * 43'(p2);
            c_pc_reg   <= {b_b3_reg, 16'h0000};
        end
    end

    assign out_valid = c_valid_reg;
    assign out_ctrl  = c_ctrl_reg;
    assign out_pa    = c_pa_reg;
    assign out_pb    = c_pb_reg;
    assign out_pc    = c_pc_reg;

endmodule

`default_nettype wire

// ----- hdl/cubic_bezier_easing_eval_top.sv -----
// Path: input stage, the bisection iterations, y evaluation, final stage and output register.
// Throughput: one word per cycle; the unrolled bisection pipeline and the output skid stage
// set that figure, and the pipeline freezes only while the skid stage holds a word.
// Reset: synchronous, active low; clears every valid bit and the output and skid stages,
// after which s_ready is high.
// ----------------------------------------------------------------------------
// cubic_bezier_easing_eval_top
// Eased value of a unit cubic Bezier timing curve chosen from an eight-entry table.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_easing_eval_top #(
    parameter int ITERATIONS = 24
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [3:0]         s_curve_id,
    input  wire logic signed [17:0] s_t,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [17:0]      m_y
);
    import cbe_pkg::*;

    // The whole pipeline advances together. It stops only when the skid
    // stage is holding a word, so s_ready comes straight from a register.
    logic en;

    // Input stage: classify the word and seed the bisection. The search
    // interval always has a power-of-two width, so each midpoint is just the
    // low bound with one more bit set, and the upper bound is never carried.
    logic        in_valid_reg;
    ctrl_t       in_ctrl_reg;
    ctrl_t       in_ctrl;
    logic [2:0]  cid_map;

    always_comb begin
        cid_map = (32'(s_curve_id) >= NUM_CURVES) ? DEFAULT_CURVE : s_curve_id[2:0];
        in_ctrl.cid = cid_map;
        in_ctrl.tq  = s_t[15:0];
        in_ctrl.lo  = 24'h00_0000;
        in_ctrl.mid = 24'h80_0000;
        if (s_t <= 18'sd0) begin
            in_ctrl.mode = MODE_ZERO;
        end else if (s_t >= 18'sd65536) begin
            in_ctrl.mode = MODE_ONE;
        end else if (cid_map == LINEAR_CURVE) begin
            in_ctrl.mode = MODE_LIN;
        end else begin
            in_ctrl.mode = MODE_CURVE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s_valid) begin
            in_ctrl_reg <= in_ctrl;
        end
    end

    // Bisection chain. Iteration k evaluates x(mid) over three stages and
    // compares it with t in a fourth. The midpoint of the last iteration is
    // the final parameter, so its own comparison is never needed and the
    // chain holds ITERATIONS - 1 comparing iterations.
    logic  stg_valid [ITERATIONS];
    ctrl_t stg_ctrl  [ITERATIONS];

    assign stg_valid[0] = in_valid_reg;
    assign stg_ctrl[0]  = in_ctrl_reg;

    for (genvar k = 0; k < ITERATIONS - 1; k++) begin : g_iter
        localparam logic [23:0] HALF = (k < 23) ? (24'd1 << (22 - k)) : 24'd0;

        logic        ev_valid;
        ctrl_t       ev_ctrl;
        logic [42:0] ev_pa, ev_pb;
        logic [39:0] ev_pc;
        logic [44:0] xval;
        logic [39:0] target;
        logic [23:0] lo_next;
        logic        cmp_valid_reg;
        ctrl_t       cmp_ctrl_reg;
        ctrl_t       cmp_ctrl_next;

        cbe_eval #(
            .AXIS_Y (1'b0)
        ) u_eval_x (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (stg_valid[k]),
            .in_ctrl   (stg_ctrl[k]),
            .out_valid (ev_valid),
            .out_ctrl  (ev_ctrl),
            .out_pa    (ev_pa),
            .out_pb    (ev_pb),
            .out_pc    (ev_pc)
        );

        // The upper half is kept when x(mid) is still short of t.
        always_comb begin
            xval    = 45'(ev_pa) + 45'(ev_pb) + 45'(ev_pc);
            target  = {ev_ctrl.tq, 24'h00_0000};
            lo_next = (xval < 45'(target)) ? ev_ctrl.mid : ev_ctrl.lo;
            cmp_ctrl_next     = ev_ctrl;
            cmp_ctrl_next.lo  = lo_next;
            cmp_ctrl_next.mid = lo_next | HALF;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cmp_valid_reg <= 1'b0;
            end else if (en) begin
                cmp_valid_reg <= ev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                cmp_ctrl_reg <= cmp_ctrl_next;
            end
        end

        assign stg_valid[k + 1] = cmp_valid_reg;
        assign stg_ctrl[k + 1]  = cmp_ctrl_reg;
    end

    // The y cubic at the final parameter.
    logic        ye_valid;
    ctrl_t       ye_ctrl;
    logic [42:0] ye_pa, ye_pb;
    logic [39:0] ye_pc;

    cbe_eval #(
        .AXIS_Y (1'b1)
    ) u_eval_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (stg_valid[ITERATIONS - 1]),
        .in_ctrl   (stg_ctrl[ITERATIONS - 1]),
        .out_valid (ye_valid),
        .out_ctrl  (ye_ctrl),
        .out_pa    (ye_pa),
        .out_pb    (ye_pb),
        .out_pc    (ye_pc)
    );

    // Final stage: round to Q16 with ties upward, saturate, and pick the
    // result that the word's class calls for.
    logic [45:0] ysum;
    logic [21:0] yround;
    logic [17:0] ysat;
    logic [17:0] y_next;
    logic        fin_valid_reg;
    logic [17:0] fin_y_reg;

    always_comb begin
        ysum   = 46'(ye_pa) + 46'(ye_pb) + 46'(ye_pc) + 46'h00_0080_0000;
        yround = ysum[45:24];
        ysat   = (yround > 22'(Y_MAX)) ? Y_MAX : yround[17:0];
        case (ye_ctrl.mode)
            MODE_ZERO:  y_next = 18'd0;
            MODE_ONE:   y_next = Y_ONE;
            MODE_LIN:   y_next = {2'b00, ye_ctrl.tq};
            MODE_CURVE: y_next = ysat;
            default:    y_next = 18'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= ye_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_y_reg <= y_next;
        end
    end

    // Output register with a skid stage behind it. A finished word that
    // meets a stalled output register is parked in the skid stage, and the
    // pipeline then holds still until the skid stage has been emptied.
    logic        out_valid_reg, out_valid_next;
    logic [17:0] out_y_reg, out_y_next;
    logic        skid_valid_reg, skid_valid_next;
    logic [17:0] skid_y_reg, skid_y_next;
    logic        pop;

    assign en  = !skid_valid_reg;
    assign pop = out_valid_reg && m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_y_next      = out_y_reg;
        skid_valid_next = skid_valid_reg;
        skid_y_next     = skid_y_reg;
        if (skid_valid_reg) begin
            if (pop || !out_valid_reg) begin
                out_valid_next  = 1'b1;
                out_y_next      = skid_y_reg;
                skid_valid_next = 1'b0;
            end
        end else if (fin_valid_reg) begin
            if (pop || !out_valid_reg) begin
                out_valid_next = 1'b1;
                out_y_next     = fin_y_reg;
            end else begin
                skid_valid_next = 1'b1;
                skid_y_next     = fin_y_reg;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_y_reg  <= out_y_next;
        skid_y_reg <= skid_y_next;
    end

    assign s_ready = en;
    assign m_valid = out_valid_reg;
    assign m_y     = out_y_reg;

endmodule

`default_nettype wire

// ----- hdl/cbe_port_chk.sv -----
// ----------------------------------------------------------------------------
// cbe_port_chk
// Checks on the ports of the easing evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cubic_bezier_easing_eval_top_macros.svh"

module cbe_port_chk (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [17:0] m_y
);

    // Results saturate at 131071, so the sign bit never shows.
    `CBE_ASSERT_NOW(a_y_nonneg, aclk, aresetn, m_valid, !m_y[17])

    // A stalled result word stays offered and unchanged.
    `CBE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `CBE_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_y))

    // Reset empties the output and skid stages and opens the input side.
    `CBE_ASSERT_RESET(a_rst_empty, aclk, aresetn, !m_valid)
    `CBE_ASSERT_RESET(a_rst_ready, aclk, aresetn, s_ready)

endmodule

bind cubic_bezier_easing_eval_top cbe_port_chk u_port_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_y        (m_y)
);

`default_nettype wire

// ----- bench/cubic_bezier_easing_eval_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_bezier_easing_eval_top_tb
// Drives curve numbers and progress values into the easing evaluator through
// the input handshake, predicts each eased value with a bit-accurate model of
// the bisection and the Bezier evaluation, and compares the returned words in
// order. Both sides idle at random, and one long output stall fills the block.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_easing_eval_top_tb;

    import cbe_pkg::*;

    localparam int LATENCY     = 4 * 24 + 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 2000;
    localparam longint U_ONE   = 64'd1 << 24;
    localparam longint T_ONE   = 64'd1 << 16;

    typedef struct {
        logic [3:0]         curve_id;
        logic signed [17:0] t;
    } easing_word_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [3:0]         s_curve_id;
    logic signed [17:0] s_t;
    logic               m_valid;
    logic               m_ready;
    logic signed [17:0] m_y;

    easing_word_t       pending_words[$];
    logic signed [17:0] expected_y[$];
    int                 error_count = 0;
    int                 cycle_count = 0;
    bit                 stimulus_done;
    int                 send_gap;
    int                 recv_gap;
    int                 hold_off;
    int                 results_seen;

    cubic_bezier_easing_eval_top u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_curve_id (s_curve_id),
        .s_t        (s_t),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_y        (m_y)
    );

    // Control points in hundredths, quantised the same way as the block does.
    function automatic longint quantise(input int hundredths);
        return ((longint'(hundredths) <<< 16) + 50) / 100;
    endfunction

    // One axis of the cubic at parameter u, with 40 fraction bits.
    function automatic longint axis_cubic(input longint u, input longint p1,
                                          input longint p2);
        longint m, mm, uu, b1, b2, b3;
        m  = U_ONE - u;
        mm = (m * m) >> 24;
        uu = (u * u) >> 24;
        b1 = (3 * mm * u) >> 24;
        b2 = (3 * m * uu) >> 24;
        b3 = (uu * u) >> 24;
        return b1 * p1 + b2 * p2 + b3 * T_ONE;
    endfunction

    function automatic logic signed [17:0] eased_value(input logic [3:0] id,
                                                       input logic signed [17:0] t);
        int     cx1[8] = '{0, 23, 65, 50, 15, 16, 34, 16};
        int     cy1[8] = '{0, 100, 5, 50, 0, 100, 156, 124};
        int     cx2[8] = '{100, 32, 36, 75, 10, 30, 64, 30};
        int     cy2[8] = '{100, 100, 100, 100, 100, 100, 100, 100};
        int     sel;
        longint tv, x1, y1, x2, y2, lo, hi, mid, v;
        tv = t;
        if (tv <= 0)
            return '0;
        if (tv >= T_ONE)
            return 18'sd65536;
        sel = (id >= NUM_CURVES) ? int'(DEFAULT_CURVE) : int'(id);
        x1 = quantise(cx1[sel]);
        y1 = quantise(cy1[sel]);
        x2 = quantise(cx2[sel]);
        y2 = quantise(cy2[sel]);
        // The linear curve passes t straight through.
        if (x1 == 0 && y1 == 0 && x2 == T_ONE && y2 == T_ONE)
            return t;
        lo  = 0;
        hi  = U_ONE;
        mid = 0;
        for (int i = 0; i < 24; i++) begin
            mid = (lo + hi) >> 1;
            if (axis_cubic(mid, x1, x2) < (tv <<< 24))
                lo = mid;
            else
                hi = mid;
        end
        v = axis_cubic(mid, y1, y2);
        if (v < 0)
            v = 0;
        v = (v + (64'd1 << 23)) >> 24;
        if (v > 131071)
            v = 131071;
        return v[17:0];
    endfunction

    task automatic queue_word(input logic [3:0] id, input logic signed [17:0] t);
        easing_word_t w;
        w.curve_id = id;
        w.t        = t;
        pending_words.push_back(w);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Directed words first, then random ones, most of them inside (0, 1).
    initial begin
        logic signed [17:0] rt;
        aresetn       = 1'b0;
        stimulus_done = 1'b0;
        for (int id = 0; id < 16; id++)
            queue_word(4'(id), 18'sd32768);
        queue_word(4'd1, 18'sd0);
        queue_word(4'd6, -18'sd131072);
        queue_word(4'd6, 18'sd65536);
        queue_word(4'd2, 18'sd131071);
        queue_word(4'd7, 18'sd1);
        queue_word(4'd6, 18'sd65535);
        queue_word(4'd0, 18'sd12345);
        queue_word(4'd15, -18'sd1);
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 9) < 8)
                rt = 18'($urandom_range(1, 65535));
            else
                rt = 18'($urandom);
            queue_word(4'($urandom_range(0, 15)), rt);
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_words.size() == 0 && !s_valid);
        stimulus_done = 1'b1;
    end

    // Sender: offers a word, holds it until taken, then idles a random while.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_curve_id <= '0;
            s_t        <= '0;
            send_gap   <= 0;
        end else if (s_valid && !s_ready) begin
            // Word still on offer; nothing changes.
        end else begin
            if (s_valid)
                expected_y.push_back(eased_value(s_curve_id, s_t));
            if (send_gap > 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_words.size() > 0) begin
                easing_word_t w;
                w = pending_words.pop_front();
                s_valid    <= 1'b1;
                s_curve_id <= w.curve_id;
                s_t        <= w.t;
                // Long stretches without gaps keep the pipeline full.
                send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random idling, and once a long stall of its own so that the
    // pipeline fills and the block holds off the sender.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            recv_gap     <= 0;
            hold_off     <= 0;
            results_seen <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_y.size() == 0) begin
                    $display("%0t: unexpected word y=%0d", $time, m_y);
                    error_count++;
                end else begin
                    logic signed [17:0] want;
                    want = expected_y.pop_front();
                    if (m_y !== want) begin
                        $display("%0t: y mismatch, expected %0d, actual %0d",
                                 $time, want, m_y);
                        error_count++;
                    end
                end
            end
            if (results_seen == 40 && hold_off == 0) begin
                hold_off <= 300;
                m_ready  <= 1'b0;
            end else if (hold_off > 1) begin
                hold_off <= hold_off - 1;
                m_ready  <= 1'b0;
            end else if (recv_gap > 0) begin
                hold_off <= (hold_off == 1) ? -1 : hold_off;
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                hold_off <= (hold_off == 1) ? -1 : hold_off;
                m_ready  <= 1'b1;
                if (m_valid && m_ready)
                    recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            end
        end
    end

    // Run control: wait for every expected word, then allow the pipeline to
    // drain in case anything stray is still coming.
    initial begin
        wait (stimulus_done);
        while (expected_y.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
        if (error_count == 0 && expected_y.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

`default_nettype wire
